// ----- src/lps_pkg.sv -----
package lps_pkg;

	localparam int LABEL_COUNT = 8;
	localparam int LABEL_BITS  = 3;
	localparam int MAX_PRIMS   = 1024;
	localparam int TALLY_BITS  = 11;
	localparam int COORD_BITS  = 20;
	localparam int EXT_BITS    = COORD_BITS + 1;
	localparam int PROD_BITS   = 2 * EXT_BITS;
	localparam int AREA_BITS   = PROD_BITS + 3;
	localparam int SCORE_BITS  = 64;
	localparam int MASK_BITS   = 8;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [MASK_BITS-1:0] mask_t;
	typedef logic [TALLY_BITS-1:0] tally_t;
	typedef logic [SCORE_BITS-1:0] score_t;

	typedef struct packed {
		coord_t min_x;
		coord_t min_y;
		coord_t min_z;
		coord_t max_x;
		coord_t max_y;
		coord_t max_z;
	} box_t;

	typedef struct packed {
		logic [LABEL_BITS-1:0] prim_label;
		box_t                  box;
		mask_t                 node_label_mask;
		logic                  last_item;
	} in_item_t;

	typedef struct packed {
		mask_t best_left_mask;
		logic  split_found;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_NEXT,
		ST_GATHER,
		ST_AREA,
		ST_MUL,
		ST_SCORE,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // merge accepted item
		logic start;     // latch mask, begin search
		logic next;      // step trial mask
		logic gather;    // merge boxes for trial
		logic area;      // extents products
		logic mul;       // area times count
		logic score;     // sum and compare
		logic clear;     // clear tallies
	} cmd_t;

	typedef struct packed {
		logic trial_zero;   // walk finished
		logic trial_skip;   // trial larger than complement
	} status_t;

endpackage

// ----- src/lps_if.sv -----
interface lps_in_if;
	logic valid;
	logic ready;
	lps_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lps_out_if;
	logic valid;
	logic ready;
	lps_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- src/lps_ctrl.sv -----
module lps_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_last,
	output logic             in_ready,
	input  logic             out_busy,
	output logic             out_load,
	input  lps_pkg::status_t status,
	output lps_pkg::cmd_t    cmd
);
	lps_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= lps_pkg::ST_LOAD;
		else state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			lps_pkg::ST_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (in_last) begin
						cmd.start = 1'b1;
						state_d = lps_pkg::ST_NEXT;
					end
				end
			end
			lps_pkg::ST_NEXT: begin
				if (status.trial_zero) state_d = lps_pkg::ST_DONE;
				else if (status.trial_skip) cmd.next = 1'b1;
				else begin
					cmd.gather = 1'b1;
					state_d = lps_pkg::ST_GATHER;
				end
			end
			lps_pkg::ST_GATHER: begin
				cmd.area = 1'b1;
				state_d = lps_pkg::ST_AREA;
			end
			lps_pkg::ST_AREA: begin
				cmd.mul = 1'b1;
				state_d = lps_pkg::ST_MUL;
			end
			lps_pkg::ST_MUL: begin
				cmd.score = 1'b1;
				state_d = lps_pkg::ST_SCORE;
			end
			lps_pkg::ST_SCORE: begin
				cmd.next = 1'b1;
				state_d = lps_pkg::ST_NEXT;
			end
			lps_pkg::ST_DONE: begin
				if (!out_busy) begin
					out_load  = 1'b1;
					cmd.clear = 1'b1;
					state_d = lps_pkg::ST_LOAD;
				end
			end
			default: state_d = lps_pkg::ST_LOAD;
		endcase
	end
endmodule

// ----- src/lps_dp.sv -----
module lps_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  lps_pkg::in_item_t  item,
	input  lps_pkg::cmd_t      cmd,
	output lps_pkg::status_t   status,
	output lps_pkg::out_item_t result
);
	localparam int LC = lps_pkg::LABEL_COUNT;
	localparam int EB = lps_pkg::EXT_BITS;
	localparam int PB = lps_pkg::PROD_BITS;
	localparam int AB = lps_pkg::AREA_BITS;
	localparam int TB = lps_pkg::TALLY_BITS;

	lps_pkg::box_t  box_q   [LC];
	lps_pkg::tally_t tally_q [LC];
	lps_pkg::mask_t mask_q, trial_q, chosen_q;
	lps_pkg::score_t lowest_q;

	// per side merged box and count
	lps_pkg::box_t   sbox_s1 [2];
	logic            sused_s1 [2];
	logic [TB+2:0]   scnt_s1 [2];
	logic [AB-1:0]   sarea_s2 [2];
	lps_pkg::score_t sprod_s3 [2];

	// store update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LC; i++) tally_q[i] <= '0;
		end else if (cmd.clear) begin
			for (int i = 0; i < LC; i++) tally_q[i] <= '0;
		end else if (cmd.load && ({1'b0, item.prim_label} < (lps_pkg::LABEL_BITS+1)'(LC))) begin
			if (tally_q[item.prim_label] < TB'(lps_pkg::MAX_PRIMS))
				tally_q[item.prim_label] <= tally_q[item.prim_label] + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			automatic lps_pkg::box_t o = box_q[item.prim_label];
			automatic lps_pkg::box_t n = item.box;
			automatic logic f = (tally_q[item.prim_label] == '0);
			if (f || n.min_x < o.min_x) o.min_x = n.min_x;
			if (f || n.min_y < o.min_y) o.min_y = n.min_y;
			if (f || n.min_z < o.min_z) o.min_z = n.min_z;
			if (f || n.max_x > o.max_x) o.max_x = n.max_x;
			if (f || n.max_y > o.max_y) o.max_y = n.max_y;
			if (f || n.max_z > o.max_z) o.max_z = n.max_z;
			box_q[item.prim_label] <= o;
		end
	end

	// search registers
	logic multi;
	assign multi = (mask_q & (mask_q - 1'b1)) != '0;
	assign status.trial_zero = (trial_q == '0);
	assign status.trial_skip = trial_q > (mask_q ^ trial_q);

	lps_pkg::score_t total;
	always_comb begin
		logic [64:0] t;
		t = {1'b0, sprod_s3[0]} + {1'b0, sprod_s3[1]};
		total = t[64] ? '1 : t[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0; trial_q <= '0; chosen_q <= '0; lowest_q <= '0;
		end else if (cmd.start) begin
			mask_q   <= item.node_label_mask;
			chosen_q <= '0;
			lowest_q <= '0;
			if ((item.node_label_mask & (item.node_label_mask - 1'b1)) != '0)
				trial_q <= (item.node_label_mask - 1'b1) & item.node_label_mask;
			else
				trial_q <= '0;
		end else begin
			if (cmd.next) trial_q <= (trial_q - 1'b1) & mask_q;
			if (cmd.score && (chosen_q == '0 || total < lowest_q)) begin
				lowest_q <= total;
				chosen_q <= trial_q;
			end
		end
	end

	// stage 1: merge label boxes per side
	always_ff @(posedge clk) begin
		if (cmd.gather) begin
			for (int s = 0; s < 2; s++) begin
				automatic lps_pkg::box_t b = '0;
				automatic logic u = 1'b0;
				automatic logic [TB+2:0] c = '0;
				for (int l = 0; l < LC; l++) begin
					if (tally_q[l] != '0 && (trial_q[l] == (s == 0))) begin
						if (!u || box_q[l].min_x < b.min_x) b.min_x = box_q[l].min_x;
						if (!u || box_q[l].min_y < b.min_y) b.min_y = box_q[l].min_y;
						if (!u || box_q[l].min_z < b.min_z) b.min_z = box_q[l].min_z;
						if (!u || box_q[l].max_x > b.max_x) b.max_x = box_q[l].max_x;
						if (!u || box_q[l].max_y > b.max_y) b.max_y = box_q[l].max_y;
						if (!u || box_q[l].max_z > b.max_z) b.max_z = box_q[l].max_z;
						u = 1'b1;
						c = c + (TB+3)'(tally_q[l]);
					end
				end
				sbox_s1[s]  <= b;
				sused_s1[s] <= u;
				scnt_s1[s]  <= c;
			end
		end
	end

	function automatic logic [EB-1:0] ext(input lps_pkg::coord_t lo, input lps_pkg::coord_t hi);
		logic signed [EB-1:0] d;
		d = EB'(hi) - EB'(lo);
		return d[EB-1] ? '0 : d;
	endfunction

	// stage 2: surface area
	always_ff @(posedge clk) begin
		if (cmd.area) begin
			for (int s = 0; s < 2; s++) begin
				automatic logic [EB-1:0] ex = ext(sbox_s1[s].min_x, sbox_s1[s].max_x);
				automatic logic [EB-1:0] ey = ext(sbox_s1[s].min_y, sbox_s1[s].max_y);
				automatic logic [EB-1:0] ez = ext(sbox_s1[s].min_z, sbox_s1[s].max_z);
				automatic logic [PB-1:0] pxy = ex * ey;
				automatic logic [PB-1:0] pyz = ey * ez;
				automatic logic [PB-1:0] pzx = ez * ex;
				automatic logic [AB-1:0] sum = AB'(pxy) + AB'(pyz) + AB'(pzx);
				sarea_s2[s] <= sused_s1[s] ? {sum[AB-2:0], 1'b0} : '0;
			end
		end
	end

	// stage 3: area times count
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			for (int s = 0; s < 2; s++)
				sprod_s3[s] <= 64'(sarea_s2[s]) * 64'(scnt_s1[s]);
		end
	end

	assign result.best_left_mask = chosen_q;
	assign result.split_found    = multi;
endmodule

// ----- src/label_partition_sah_split_core.sv -----
// label_partition_sah_split_core: per-label box merge and SAH submask search.
// Load phase: one primitive item per cycle, result-free items need no stall.
// After the last item the FSM walks the submasks: a skipped one only steps the
// trial mask; a scored one runs through NEXT, GATHER, AREA, MUL and SCORE on the
// shared datapath. At walk end DONE loads the output, waiting while the sink stalls.
// arst_n low clears tallies, search registers, FSM and output valid.
module label_partition_sah_split_core (
	input  logic      clk,
	input  logic      arst_n,
	lps_in_if.sink    in_ch,
	lps_out_if.source out_ch
);
	lps_pkg::cmd_t      cmd;
	lps_pkg::status_t   status;
	lps_pkg::out_item_t result;
	logic out_load;
	logic out_valid_q;
	lps_pkg::out_item_t out_data_q;

	lps_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_last(in_ch.data.last_item),
		.in_ready(in_ch.ready),
		.out_busy(out_valid_q && !out_ch.ready),
		.out_load(out_load), .status(status), .cmd(cmd)
	);

	lps_dp u_dp (
		.clk(clk), .arst_n(arst_n), .item(in_ch.data),
		.cmd(cmd), .status(status), .result(result)
	);

	// output register: holds the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (out_load) out_valid_q <= 1'b1;
		else if (out_ch.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) out_data_q <= result;
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_data_q;

`ifndef SYNTHESIS
	a_no_split_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.data.split_found |-> out_ch.data.best_left_mask == '0)
		else $error("left mask without split");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !out_valid_q || out_ch.ready)
		else $error("result overwritten");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.gather, cmd.area, cmd.mul, cmd.score}))
		else $error("datapath commands overlap");
`endif
endmodule

// ----- sim/tb_label_partition_sah_split_core.sv -----
`timescale 1ns / 100ps

module tb_label_partition_sah_split_core;

	logic clk;
	logic arst_n;

	lps_in_if  in_ch ();
	lps_out_if out_ch ();

	label_partition_sah_split_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int ITEM_TARGET    = 1850;
	localparam int TAIL_ITEMS     = 250;

	// primitive items waiting to be driven, and split results still owed
	lps_pkg::in_item_t  prim_queue[$];
	lps_pkg::out_item_t split_expect[$];

	// predictor state: merged box and count per label
	logic signed [lps_pkg::COORD_BITS-1:0] lbl_lo[lps_pkg::LABEL_COUNT][3];
	logic signed [lps_pkg::COORD_BITS-1:0] lbl_hi[lps_pkg::LABEL_COUNT][3];
	int unsigned                           lbl_cnt[lps_pkg::LABEL_COUNT];

	int  err_count;
	int  idle_cycles;
	bit  no_idle;
	bit  in_took;
	int  in_gap;
	int  out_gap;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [63:0] sat_mul64(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = a * b;
		return (p[127:64] != 0) ? '1 : p[63:0];
	endfunction

	function automatic logic [63:0] sat_add64(logic [63:0] a, logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? '1 : s[63:0];
	endfunction

	// sum of per-side area times count for one left mask
	function automatic logic [63:0] side_cost(lps_pkg::mask_t left);
		longint lo[2][3];
		longint hi[2][3];
		longint cnt[2];
		bit     used[2];
		logic [63:0] total, ext[3], area;
		int s;
		total = 0;
		for (s = 0; s < 2; s++) begin
			used[s] = 0;
			cnt[s] = 0;
		end
		for (int lab = 0; lab < lps_pkg::LABEL_COUNT; lab++) begin
			if (lbl_cnt[lab] != 0) begin
				s = left[lab] ? 0 : 1;
				for (int k = 0; k < 3; k++) begin
					if (!used[s] || lbl_lo[lab][k] < lo[s][k]) lo[s][k] = lbl_lo[lab][k];
					if (!used[s] || lbl_hi[lab][k] > hi[s][k]) hi[s][k] = lbl_hi[lab][k];
				end
				used[s] = 1;
				cnt[s] += lbl_cnt[lab];
			end
		end
		for (s = 0; s < 2; s++) begin
			if (used[s]) begin
				for (int k = 0; k < 3; k++)
					ext[k] = (hi[s][k] > lo[s][k]) ? 64'(hi[s][k] - lo[s][k]) : 64'd0;
				area = sat_mul64(64'd2, sat_add64(sat_add64(sat_mul64(ext[0], ext[1]),
					sat_mul64(ext[1], ext[2])), sat_mul64(ext[2], ext[0])));
				total = sat_add64(total, sat_mul64(area, 64'(cnt[s])));
			end
		end
		return total;
	endfunction

	// fold one accepted primitive in; on the last item, queue the best split
	task automatic predict_split(lps_pkg::in_item_t it);
		logic signed [lps_pkg::COORD_BITS-1:0] mn[3], mx[3];
		int lab;
		lps_pkg::mask_t m, t, best;
		logic [63:0] low, sc;
		lps_pkg::out_item_t r;
		lab = int'(it.prim_label);
		mn = '{it.box.min_x, it.box.min_y, it.box.min_z};
		mx = '{it.box.max_x, it.box.max_y, it.box.max_z};
		if (lab < lps_pkg::LABEL_COUNT) begin
			for (int k = 0; k < 3; k++) begin
				if (lbl_cnt[lab] == 0 || mn[k] < lbl_lo[lab][k]) lbl_lo[lab][k] = mn[k];
				if (lbl_cnt[lab] == 0 || mx[k] > lbl_hi[lab][k]) lbl_hi[lab][k] = mx[k];
			end
			if (lbl_cnt[lab] < lps_pkg::MAX_PRIMS) lbl_cnt[lab]++;
		end
		if (!it.last_item) return;
		m = it.node_label_mask;
		best = 0;
		low = 0;
		if ((m & (m - 1'b1)) != 0) begin
			for (t = (m - 1'b1) & m; t != 0; t = (t - 1'b1) & m) begin
				if (t <= (m ^ t)) begin
					sc = side_cost(t);
					if (best == 0 || sc < low) begin
						low = sc;
						best = t;
					end
				end
			end
		end
		r.best_left_mask = best;
		r.split_found = ((m & (m - 1'b1)) != 0);
		split_expect = {split_expect, r};
		for (int i = 0; i < lps_pkg::LABEL_COUNT; i++) lbl_cnt[i] = 0;
	endtask

	function automatic lps_pkg::coord_t rand_coord(int mode);
		case (mode)
			0: return lps_pkg::coord_t'(20'h80000);
			1: return lps_pkg::coord_t'(20'h7FFFF);
			2: return lps_pkg::coord_t'($urandom_range(2047) - 1024);
			default: return lps_pkg::coord_t'($urandom);
		endcase
	endfunction

	function automatic lps_pkg::in_item_t make_prim(int lab, bit last, lps_pkg::mask_t m,
			int mode);
		lps_pkg::in_item_t it;
		lps_pkg::coord_t a, b;
		it.prim_label = lps_pkg::LABEL_BITS'(lab);
		it.last_item = last;
		it.node_label_mask = m;
		a = rand_coord(mode); b = rand_coord(mode);
		// mostly proper boxes, sometimes inverted
		if ($urandom_range(9) != 0 && a > b) begin it.box.min_x = b; it.box.max_x = a; end
		else begin it.box.min_x = a; it.box.max_x = b; end
		a = rand_coord(mode); b = rand_coord(mode);
		if ($urandom_range(9) != 0 && a > b) begin it.box.min_y = b; it.box.max_y = a; end
		else begin it.box.min_y = a; it.box.max_y = b; end
		a = rand_coord(mode); b = rand_coord(mode);
		if ($urandom_range(9) != 0 && a > b) begin it.box.min_z = b; it.box.max_z = a; end
		else begin it.box.min_z = a; it.box.max_z = b; end
		return it;
	endfunction

	// driver: inputs move on the falling edge; a shown item stays until taken
	always @(negedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			out_ch.ready <= 1'b0;
			in_took = 1'b0;
		end else begin
			no_idle = (prim_queue.size() < TAIL_ITEMS);
			if (in_took || !in_ch.valid) begin
				if (in_gap > 0) begin
					in_gap--;
					in_ch.valid <= 1'b0;
				end else if (!no_idle && $urandom_range(15) == 0) begin
					in_gap = $urandom_range(13);
					in_ch.valid <= 1'b0;
				end else if (prim_queue.size() != 0) begin
					in_ch.valid <= 1'b1;
					in_ch.data <= prim_queue[0];
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
			in_took = 1'b0;
			if (out_gap > 0) begin
				out_gap--;
				out_ch.ready <= 1'b0;
			end else if (!no_idle && $urandom_range(7) == 0) begin
				out_gap = $urandom_range(13);
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// monitor: sample on the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			idle_cycles = idle_cycles + 1;
			if (in_ch.valid && in_ch.ready) begin
				predict_split(in_ch.data);
				void'(prim_queue.pop_front());
				in_took = 1'b1;
				idle_cycles = 0;
			end
			if (out_ch.valid && out_ch.ready) begin
				idle_cycles = 0;
				if (split_expect.size() == 0) begin
					$error("unexpected result best_left_mask=%0h", out_ch.data.best_left_mask);
					err_count++;
				end else begin
					if (out_ch.data.best_left_mask !== split_expect[0].best_left_mask) begin
						$error("best_left_mask expected %0h actual %0h",
							split_expect[0].best_left_mask, out_ch.data.best_left_mask);
						err_count++;
					end
					if (out_ch.data.split_found !== split_expect[0].split_found) begin
						$error("split_found expected %0b actual %0b",
							split_expect[0].split_found, out_ch.data.split_found);
						err_count++;
					end
					void'(split_expect.pop_front());
				end
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_label_partition_sah_split_core: errors");
				$finish;
			end
		end
	end

	initial begin
		int lab, mode;
		lps_pkg::mask_t m;
		err_count = 0;
		idle_cycles = 0;
		no_idle = 0;
		in_took = 0;
		in_gap = 0;
		out_gap = 0;
		for (int i = 0; i < lps_pkg::LABEL_COUNT; i++) lbl_cnt[i] = 0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: corner coordinates, all-zero and single-label masks
		prim_queue = {prim_queue, make_prim(0, 0, 8'h00, 0)};
		prim_queue = {prim_queue, make_prim(7, 0, 8'h00, 1)};
		prim_queue = {prim_queue, make_prim(3, 1, 8'hFF, 3)};
		prim_queue = {prim_queue, make_prim(2, 1, 8'h00, 2)};
		prim_queue = {prim_queue, make_prim(2, 1, 8'h04, 2)};
		// extreme full-range boxes, two labels
		begin
			lps_pkg::in_item_t it;
			it = make_prim(1, 0, 8'h00, 2);
			it.box = '{20'h80000, 20'h80000, 20'h80000, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF};
			prim_queue = {prim_queue, it};
			it.prim_label = 3'd6; it.last_item = 1; it.node_label_mask = 8'h42;
			prim_queue = {prim_queue, it};
		end
		// mask bits without primitives, inverted boxes
		prim_queue = {prim_queue, make_prim(0, 0, 8'h00, 3)};
		prim_queue = {prim_queue, make_prim(5, 1, 8'hB1, 3)};
		// tally saturation on one label
		for (int i = 0; i < lps_pkg::MAX_PRIMS + 3; i++)
			prim_queue = {prim_queue, make_prim(4, 0, 8'h00, 2)};
		prim_queue = {prim_queue, make_prim(2, 1, 8'h16, 2)};

		// random nodes, small mostly
		while (prim_queue.size() < ITEM_TARGET) begin
			int sz;
			m = lps_pkg::mask_t'($urandom);
			sz = ($urandom_range(19) == 0) ? $urandom_range(60) : $urandom_range(8);
			mode = $urandom_range(3);
			for (int i = 0; i <= sz; i++) begin
				// mostly labels from the node mask
				lab = $urandom_range(7);
				if (m != 0 && $urandom_range(4) != 0)
					while (!m[lab]) lab = $urandom_range(7);
				prim_queue = {prim_queue, make_prim(lab, i == sz,
					(i == sz) ? m : lps_pkg::mask_t'($urandom),
					$urandom_range(3) == 0 ? $urandom_range(3) : mode)};
			end
		end

		wait (prim_queue.size() == 0);
		wait (split_expect.size() == 0);
		repeat (300) @(posedge clk);
		if (err_count == 0 && split_expect.size() == 0) begin
			$display("tb_label_partition_sah_split_core: clean");
		end else begin
			$display("tb_label_partition_sah_split_core: errors");
		end
		$finish;
	end

endmodule
